// ===== rtl/core/gnms_pkg.sv =====
package gnms_pkg;

  localparam int IMG_W_BITS = 12;
  localparam int IMG_H_BITS = 13;
  localparam int ROW_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [IMG_W_BITS-1:0] WIDTH_RESET = 12'd640;
  localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [IMG_H_BITS-1:0] MIN_SIZE = 13'd3;
  localparam logic [IMG_H_BITS-1:0] MAX_HEIGHT = 13'd4096;

  // tan(pi/8) as an unsigned Q0.16 fraction.
  localparam int FRAC_BITS = 16;
  localparam int TAN_BITS = 15;
  localparam logic [TAN_BITS-1:0] TAN_Q16 = 15'd27146;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       end_of_row;
    logic       emit;
    logic       end_of_frame;
    logic [2:0] row_ok;
    logic       left_ok;
    logic       right_ok;
  } nms_ctl_t;

  localparam int CTL_W = $bits(nms_ctl_t);

endpackage

// ===== rtl/core/gradient_non_max_suppression_top.sv =====
// Channel   Direction  Handshake               Word
// in_       input      in_valid / in_ready     grad_x, grad_y, magnitude, drain
// out_      output     out_valid / out_ready   thin_magnitude, end_of_row, end_of_frame
// cfg_      input      cfg_wr_en               cfg_index, cfg_data
//
// One input word is taken per clock when the output side keeps up.
// A window's result passes the p register, the queue, the s1 register and the output register.
// Line stores are simple dual-port RAMs, read when a word is taken, written in the next cycle.
// Reset clears position and queue; line RAMs need no clearing pass.
// in_ready drops once the four-entry queue between front and back plus the pending word hold four.
module gradient_non_max_suppression_top #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAG_BITS = 16,
  parameter int GRAD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [gnms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gnms_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [GRAD_BITS-1:0]     in_grad_x,
  input  logic signed [GRAD_BITS-1:0]     in_grad_y,
  input  logic [MAG_BITS-1:0]             in_magnitude,
  input  logic                            in_drain,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [MAG_BITS-1:0]             out_thin_magnitude,
  output logic                            out_end_of_row,
  output logic                            out_end_of_frame
);

  localparam int QW = gnms_pkg::CTL_W + 3 * MAG_BITS + 2 * GRAD_BITS;

  logic                            push;
  gnms_pkg::nms_ctl_t              push_ctl;
  logic [MAG_BITS-1:0]             push_top;
  logic [MAG_BITS-1:0]             push_mid;
  logic [MAG_BITS-1:0]             push_mag;
  logic signed [GRAD_BITS-1:0]     push_gx;
  logic signed [GRAD_BITS-1:0]     push_gy;
  logic [gnms_pkg::QCNT_W-1:0]     q_count;
  logic                            q_valid;
  logic                            q_pop;
  logic [QW-1:0]                   q_wdata;
  logic [QW-1:0]                   q_rdata;
  gnms_pkg::nms_ctl_t              q_ctl;
  logic [MAG_BITS-1:0]             q_top;
  logic [MAG_BITS-1:0]             q_mid;
  logic [MAG_BITS-1:0]             q_mag;
  logic signed [GRAD_BITS-1:0]     q_gx;
  logic signed [GRAD_BITS-1:0]     q_gy;

  gnms_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAG_BITS(MAG_BITS),
    .GRAD_BITS(GRAD_BITS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_grad_x(in_grad_x),
    .in_grad_y(in_grad_y),
    .in_magnitude(in_magnitude),
    .in_drain(in_drain),
    .q_count(q_count),
    .push(push),
    .push_ctl(push_ctl),
    .push_top(push_top),
    .push_mid(push_mid),
    .push_mag(push_mag),
    .push_gx(push_gx),
    .push_gy(push_gy)
  );

  assign q_wdata = {push_ctl, push_top, push_mid, push_mag, push_gx, push_gy};

  gnms_fifo #(
    .WIDTH(QW),
    .DEPTH(gnms_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_data(q_wdata),
    .pop(q_pop),
    .pop_data(q_rdata),
    .not_empty(q_valid),
    .count(q_count)
  );

  assign q_ctl = gnms_pkg::nms_ctl_t'(q_rdata[QW-1 -: gnms_pkg::CTL_W]);
  assign q_top = q_rdata[3*MAG_BITS+2*GRAD_BITS-1 -: MAG_BITS];
  assign q_mid = q_rdata[2*MAG_BITS+2*GRAD_BITS-1 -: MAG_BITS];
  assign q_mag = q_rdata[MAG_BITS+2*GRAD_BITS-1 -: MAG_BITS];
  assign q_gx = $signed(q_rdata[2*GRAD_BITS-1 -: GRAD_BITS]);
  assign q_gy = $signed(q_rdata[GRAD_BITS-1:0]);

  gnms_back #(
    .MAG_BITS(MAG_BITS),
    .GRAD_BITS(GRAD_BITS)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_pop(q_pop),
    .q_ctl(q_ctl),
    .q_top(q_top),
    .q_mid(q_mid),
    .q_mag(q_mag),
    .q_gx(q_gx),
    .q_gy(q_gy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_thin_magnitude(out_thin_magnitude),
    .out_end_of_row(out_end_of_row),
    .out_end_of_frame(out_end_of_frame)
  );

endmodule

// ===== rtl/core/gnms_ram.sv =====
module gnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/gnms_fifo.sv =====
module gnms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNTW'(DEPTH)))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !pop)
    else $error("Queue read while empty.");

endmodule

// ===== rtl/core/gnms_front.sv =====
module gnms_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAG_BITS = 16,
  parameter int GRAD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [gnms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gnms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [GRAD_BITS-1:0]         in_grad_x,
  input  logic signed [GRAD_BITS-1:0]         in_grad_y,
  input  logic [MAG_BITS-1:0]                 in_magnitude,
  input  logic                                in_drain,
  input  logic [gnms_pkg::QCNT_W-1:0]         q_count,
  output logic                                push,
  output gnms_pkg::nms_ctl_t                  push_ctl,
  output logic [MAG_BITS-1:0]                 push_top,
  output logic [MAG_BITS-1:0]                 push_mid,
  output logic [MAG_BITS-1:0]                 push_mag,
  output logic signed [GRAD_BITS-1:0]         push_gx,
  output logic signed [GRAD_BITS-1:0]         push_gy
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > gnms_pkg::IMG_W_BITS) ? WW : gnms_pkg::IMG_W_BITS;
  localparam int RW = gnms_pkg::ROW_W;
  localparam int RW1 = RW + 1;

  logic [gnms_pkg::IMG_W_BITS-1:0] width_r, width_nxt;
  logic [gnms_pkg::IMG_H_BITS-1:0] height_r, height_nxt;
  logic [CW-1:0]                   col_r, col_nxt;
  logic [RW-1:0]                   row_r, row_nxt;

  logic                            p_valid_r;
  gnms_pkg::nms_ctl_t              p_ctl_r;
  logic [CW-1:0]                   p_col_r;
  logic [MAG_BITS-1:0]             p_mag_r;
  logic signed [GRAD_BITS-1:0]     p_gx_r;
  logic signed [GRAD_BITS-1:0]     p_gy_r;

  logic [CMPW-1:0]                 w_ext;
  logic [CMPW-1:0]                 w_eff;
  logic [gnms_pkg::IMG_H_BITS-1:0] h_eff;
  logic [CW-1:0]                   c_eff;
  logic [CMPW-1:0]                 c_inc;
  logic                            wrap;
  logic                            tail;
  logic                            take;
  logic                            col0;
  logic [RW1-1:0]                  r_ext;
  logic [RW1-1:0]                  h_ext;
  logic [RW1-1:0]                  off;
  gnms_pkg::nms_ctl_t              ctl;

  logic [2*MAG_BITS-1:0]           mag_rd;
  logic [2*GRAD_BITS-1:0]          grad_rd;

  assign in_ready = ({1'b0, q_count} + (gnms_pkg::QCNT_W + 1)'(p_valid_r))
                    < (gnms_pkg::QCNT_W + 1)'(gnms_pkg::QUEUE_DEPTH);

  always_comb begin
    w_ext = CMPW'(width_r);
    if (w_ext < CMPW'(3)) begin
      w_eff = CMPW'(3);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (height_r < gnms_pkg::MIN_SIZE) begin
      h_eff = gnms_pkg::MIN_SIZE;
    end else if (height_r > gnms_pkg::MAX_HEIGHT) begin
      h_eff = gnms_pkg::MAX_HEIGHT;
    end else begin
      h_eff = height_r;
    end
    c_eff = (CMPW'(col_r) >= w_eff) ? '0 : col_r;
    c_inc = CMPW'(c_eff) + CMPW'(1);
    wrap = (c_inc >= w_eff);
    tail = (RW1'(row_r) >= RW1'(h_eff));
    take = in_valid && in_ready && !(in_drain && !tail);
  end

  // The centre sits one row up and one column left of the incoming pixel,
  // or at the end of the row two up when the incoming pixel starts a row.
  always_comb begin
    col0 = (c_eff == '0);
    r_ext = RW1'(row_r);
    h_ext = RW1'(h_eff);
    off = col0 ? RW1'(3) : RW1'(2);
    for (int k = 0; k < 3; k++) begin
      ctl.row_ok[k] = ((r_ext + RW1'(k)) >= off) && ((r_ext + RW1'(k)) < (h_ext + off));
    end
    ctl.emit = ctl.row_ok[1];
    ctl.end_of_row = col0;
    ctl.end_of_frame = ctl.row_ok[1] && col0 && (r_ext == (h_ext + RW1'(1)));
    ctl.left_ok = col0 || (c_eff >= CW'(2));
    ctl.right_ok = !col0;
  end

  always_comb begin
    width_nxt = width_r;
    height_nxt = height_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        gnms_pkg::REG_IMAGE_WIDTH: begin
          width_nxt = cfg_data[gnms_pkg::IMG_W_BITS-1:0];
          col_nxt = '0;
          row_nxt = '0;
        end
        gnms_pkg::REG_IMAGE_HEIGHT: begin
          height_nxt = cfg_data[gnms_pkg::IMG_H_BITS-1:0];
          col_nxt = '0;
          row_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (take) begin
      if (ctl.end_of_frame) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (wrap) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = c_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= gnms_pkg::WIDTH_RESET;
      height_r <= gnms_pkg::HEIGHT_RESET;
      col_r <= '0;
      row_r <= '0;
      p_valid_r <= 1'b0;
    end else begin
      width_r <= width_nxt;
      height_r <= height_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      p_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_ctl_r <= ctl;
      p_col_r <= c_eff;
      p_mag_r <= tail ? '0 : in_magnitude;
      p_gx_r <= tail ? '0 : in_grad_x;
      p_gy_r <= tail ? '0 : in_grad_y;
    end
  end

  // Upper half holds the line two rows up, lower half the line one row up.
  gnms_ram #(
    .WIDTH(2 * MAG_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_mag_lines (
    .clk(clk),
    .wr_en(p_valid_r),
    .wr_addr(p_col_r),
    .wr_data({mag_rd[MAG_BITS-1:0], p_mag_r}),
    .rd_en(take),
    .rd_addr(c_eff),
    .rd_data(mag_rd)
  );

  gnms_ram #(
    .WIDTH(2 * GRAD_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_grad_line (
    .clk(clk),
    .wr_en(p_valid_r),
    .wr_addr(p_col_r),
    .wr_data({p_gx_r, p_gy_r}),
    .rd_en(take),
    .rd_addr(c_eff),
    .rd_data(grad_rd)
  );

  assign push = p_valid_r;
  assign push_ctl = p_ctl_r;
  assign push_top = mag_rd[2*MAG_BITS-1:MAG_BITS];
  assign push_mid = mag_rd[MAG_BITS-1:0];
  assign push_mag = p_mag_r;
  assign push_gx = $signed(grad_rd[2*GRAD_BITS-1:GRAD_BITS]);
  assign push_gy = $signed(grad_rd[GRAD_BITS-1:0]);

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && ctl.end_of_frame && !cfg_wr_en) |=> ((col_r == '0) && (row_r == '0)))
    else $error("Position did not return to the frame start after the last pixel.");

endmodule

// ===== rtl/core/gnms_back.sv =====
module gnms_back #(
  parameter int MAG_BITS = 16,
  parameter int GRAD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  gnms_pkg::nms_ctl_t          q_ctl,
  input  logic [MAG_BITS-1:0]         q_top,
  input  logic [MAG_BITS-1:0]         q_mid,
  input  logic [MAG_BITS-1:0]         q_mag,
  input  logic signed [GRAD_BITS-1:0] q_gx,
  input  logic signed [GRAD_BITS-1:0] q_gy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [MAG_BITS-1:0]         out_thin_magnitude,
  output logic                        out_end_of_row,
  output logic                        out_end_of_frame
);

  localparam int G = GRAD_BITS;
  localparam int PW = GRAD_BITS + gnms_pkg::TAN_BITS;
  localparam int SW = GRAD_BITS + gnms_pkg::FRAC_BITS;

  logic [MAG_BITS-1:0]  win1_r [3];
  logic [MAG_BITS-1:0]  win2_r [3];
  logic signed [G-1:0]  cg_x_r;
  logic signed [G-1:0]  cg_y_r;

  logic                 s1_valid_r, s1_valid_nxt;
  logic [MAG_BITS-1:0]  s1_c_r;
  logic [MAG_BITS-1:0]  s1_a_r;
  logic [MAG_BITS-1:0]  s1_b_r;
  logic                 s1_eor_r;
  logic                 s1_eof_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [MAG_BITS-1:0]  out_thin_r;
  logic                 out_eor_r;
  logic                 out_eof_r;

  logic                 adv_out;
  logic                 s1_free;
  logic [MAG_BITS-1:0]  col_new [3];
  logic [MAG_BITS-1:0]  nb [3][3];
  logic [G-1:0]         ax;
  logic [G-1:0]         ay;
  logic [PW-1:0]        kx;
  logic [PW-1:0]        ky;
  logic [SW-1:0]        sx;
  logic [SW-1:0]        sy;
  logic                 horiz;
  logic                 vert;
  logic                 diag_main;
  logic [MAG_BITS-1:0]  s1_a_nxt;
  logic [MAG_BITS-1:0]  s1_b_nxt;

  assign adv_out = !out_valid_r || out_ready;
  assign s1_free = !s1_valid_r || adv_out;
  assign q_pop = q_valid && s1_free;

  assign col_new[0] = q_top;
  assign col_new[1] = q_mid;
  assign col_new[2] = q_mag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nb[0][k] = (q_ctl.row_ok[k] && q_ctl.left_ok) ? win1_r[k] : '0;
      nb[1][k] = q_ctl.row_ok[k] ? win2_r[k] : '0;
      nb[2][k] = (q_ctl.row_ok[k] && q_ctl.right_ok) ? col_new[k] : '0;
    end
  end

  always_comb begin
    ax = cg_x_r[G-1] ? ($unsigned(~cg_x_r) + G'(1)) : $unsigned(cg_x_r);
    ay = cg_y_r[G-1] ? ($unsigned(~cg_y_r) + G'(1)) : $unsigned(cg_y_r);
    kx = PW'(ax) * PW'(gnms_pkg::TAN_Q16);
    ky = PW'(ay) * PW'(gnms_pkg::TAN_Q16);
    sx = {ax, gnms_pkg::FRAC_BITS'(0)};
    sy = {ay, gnms_pkg::FRAC_BITS'(0)};
    horiz = (sy < SW'(kx));
    vert = (sx < SW'(ky));
    diag_main = (cg_x_r != '0) && (cg_y_r != '0) && (cg_x_r[G-1] == cg_y_r[G-1]);
    if (horiz) begin
      s1_a_nxt = nb[0][1];
      s1_b_nxt = nb[2][1];
    end else if (vert) begin
      s1_a_nxt = nb[1][0];
      s1_b_nxt = nb[1][2];
    end else if (diag_main) begin
      s1_a_nxt = nb[0][0];
      s1_b_nxt = nb[2][2];
    end else begin
      s1_a_nxt = nb[0][2];
      s1_b_nxt = nb[2][0];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_free) begin
      s1_valid_nxt = q_pop && q_ctl.emit;
    end
    out_valid_nxt = out_valid_r;
    if (adv_out) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cg_x_r <= '0;
      cg_y_r <= '0;
      for (int k = 0; k < 3; k++) begin
        win1_r[k] <= '0;
        win2_r[k] <= '0;
      end
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        cg_x_r <= q_gx;
        cg_y_r <= q_gy;
        for (int k = 0; k < 3; k++) begin
          win1_r[k] <= win2_r[k];
          win2_r[k] <= col_new[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_c_r <= nb[1][1];
      s1_a_r <= s1_a_nxt;
      s1_b_r <= s1_b_nxt;
      s1_eor_r <= q_ctl.end_of_row;
      s1_eof_r <= q_ctl.end_of_frame;
    end
    if (adv_out && s1_valid_r) begin
      out_thin_r <= ((s1_c_r != '0) && (s1_c_r >= s1_a_r) && (s1_c_r >= s1_b_r))
                    ? s1_c_r : '0;
      out_eor_r <= s1_eor_r;
      out_eof_r <= s1_eof_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_thin_magnitude = out_thin_r;
  assign out_end_of_row = out_eor_r;
  assign out_end_of_frame = out_eof_r;

  a_eof_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eof_r) |-> out_eor_r)
    else $error("Frame end shown on a word that does not end a row.");

endmodule

// ===== tb/thin_edge_checker.sv =====
module thin_edge_checker #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAG_BITS = 16,
  parameter int GRAD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [gnms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gnms_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [GRAD_BITS-1:0]     in_grad_x,
  input  logic signed [GRAD_BITS-1:0]     in_grad_y,
  input  logic [MAG_BITS-1:0]             in_magnitude,
  input  logic                            in_drain,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [MAG_BITS-1:0]             out_thin_magnitude,
  input  logic                            out_end_of_row,
  input  logic                            out_end_of_frame,
  output int                              mismatch_count,
  output int                              thin_in_flight,
  output int                              thin_checked
);

  localparam longint TAN_FRAC = 27146;
  localparam int MIN_SIZE = 3;
  localparam int TOP_HEIGHT = 4096;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [MAG_BITS-1:0] thin;
    logic                end_of_row;
    logic                end_of_frame;
  } thin_pixel_t;

  logic [MAG_BITS-1:0]         mag_above2 [MAX_WIDTH];
  logic [MAG_BITS-1:0]         mag_above1 [MAX_WIDTH];
  logic signed [GRAD_BITS-1:0] grad_row_x [MAX_WIDTH];
  logic signed [GRAD_BITS-1:0] grad_row_y [MAX_WIDTH];
  logic [2:0][2:0][MAG_BITS-1:0] window;  // [column old..new][row top..bottom]
  logic signed [GRAD_BITS-1:0] centre_gx;
  logic signed [GRAD_BITS-1:0] centre_gy;
  logic [11:0]                 width_reg;
  logic [12:0]                 height_reg;
  int                          col_pos;
  int                          row_pos;
  thin_pixel_t                 thin_pixels_q [$];
  thin_pixel_t                 head;

  task automatic clear_state();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mag_above2[i] = '0;
      mag_above1[i] = '0;
      grad_row_x[i] = '0;
      grad_row_y[i] = '0;
    end
    window = '0;
    centre_gx = '0;
    centre_gy = '0;
    width_reg = 12'd640;
    height_reg = 13'd480;
    col_pos = 0;
    row_pos = 0;
  endtask

  function automatic logic [MAG_BITS-1:0] peak_or_zero(
    input logic [2:0][2:0][MAG_BITS-1:0] nb,
    input logic signed [GRAD_BITS-1:0] gx,
    input logic signed [GRAD_BITS-1:0] gy
  );
    longint sx, sy, ax, ay;
    logic [MAG_BITS-1:0] c, a, b;
    sx = gx;
    sy = gy;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    c = nb[1][1];
    if ((ay << 16) < TAN_FRAC * ax) begin
      a = nb[0][1];
      b = nb[2][1];
    end else if ((ax << 16) < TAN_FRAC * ay) begin
      a = nb[1][0];
      b = nb[1][2];
    end else if ((sx > 0 && sy > 0) || (sx < 0 && sy < 0)) begin
      a = nb[0][0];
      b = nb[2][2];
    end else begin
      a = nb[0][2];
      b = nb[2][0];
    end
    return (c != 0 && c >= a && c >= b) ? c : '0;
  endfunction

  task automatic advance_window(
    input logic signed [GRAD_BITS-1:0] gx_in,
    input logic signed [GRAD_BITS-1:0] gy_in,
    input logic [MAG_BITS-1:0] mag_in,
    input logic drain_in
  );
    int w, h, c, r, cr, row0, rr, k, j;
    bit tail, left_ok, right_ok, row_ok, emit, eof, eor;
    logic [MAG_BITS-1:0] m, top, mid;
    logic signed [GRAD_BITS-1:0] nx, ny, cgx, cgy;
    logic [2:0][2:0][MAG_BITS-1:0] nb;
    thin_pixel_t res;
    w = width_reg;
    h = height_reg;
    if (w < MIN_SIZE) w = MIN_SIZE;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < MIN_SIZE) h = MIN_SIZE;
    if (h > TOP_HEIGHT) h = TOP_HEIGHT;
    c = col_pos;
    r = row_pos;
    if (c >= w) c = 0;
    tail = r >= h;
    if (drain_in && !tail) return;
    m = tail ? '0 : mag_in;
    nx = tail ? '0 : gx_in;
    ny = tail ? '0 : gy_in;

    top = mag_above2[c];
    mid = mag_above1[c];
    mag_above2[c] = mid;
    mag_above1[c] = m;

    cgx = centre_gx;
    cgy = centre_gy;
    centre_gx = grad_row_x[c];
    centre_gy = grad_row_y[c];
    grad_row_x[c] = nx;
    grad_row_y[c] = ny;

    if (c == 0) begin
      cr = r - 2;
      row0 = r - 3;
      left_ok = 1'b1;
      right_ok = 1'b0;
      nb[0] = window[1];
      nb[1] = window[2];
      nb[2] = '0;
    end
    window[0] = window[1];
    window[1] = window[2];
    window[2][0] = top;
    window[2][1] = mid;
    window[2][2] = m;
    if (c != 0) begin
      cr = r - 1;
      row0 = r - 2;
      left_ok = (c >= 2);
      right_ok = 1'b1;
      nb = window;
    end

    for (k = 0; k < 3; k++) begin
      rr = row0 + k;
      row_ok = (rr >= 0) && (rr < h);
      for (j = 0; j < 3; j++) begin
        if (!(row_ok && (j != 0 || left_ok) && (j != 2 || right_ok))) nb[j][k] = '0;
      end
    end

    emit = (cr >= 0) && (cr < h);
    eof = emit && (c == 0) && (cr == h - 1);
    eor = (c == 0);

    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (eof) begin
      c = 0;
      r = 0;
    end
    col_pos = c;
    row_pos = r;

    if (emit) begin
      res.thin = peak_or_zero(nb, cgx, cgy);
      res.end_of_row = eor;
      res.end_of_frame = eof;
      thin_pixels_q.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("Mismatch on %s at result %0d: got %0h, predicted %0h",
               field, thin_checked, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      thin_pixels_q.delete();
      mismatch_count = 0;
      thin_checked = 0;
      thin_in_flight <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (thin_pixels_q.size() == 0) begin
          report_mismatch("unpredicted word", {16'd0, out_thin_magnitude}, 32'd0);
        end else begin
          head = thin_pixels_q.pop_front();
          if (out_thin_magnitude !== head.thin) begin
            report_mismatch("thin_magnitude", {16'd0, out_thin_magnitude}, {16'd0, head.thin});
          end
          if (out_end_of_row !== head.end_of_row) begin
            report_mismatch("end_of_row", {31'd0, out_end_of_row}, {31'd0, head.end_of_row});
          end
          if (out_end_of_frame !== head.end_of_frame) begin
            report_mismatch("end_of_frame", {31'd0, out_end_of_frame},
                            {31'd0, head.end_of_frame});
          end
          thin_checked++;
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == gnms_pkg::REG_IMAGE_WIDTH) begin
          width_reg = cfg_data[11:0];
          col_pos = 0;
          row_pos = 0;
        end else if (cfg_index == gnms_pkg::REG_IMAGE_HEIGHT) begin
          height_reg = cfg_data[12:0];
          col_pos = 0;
          row_pos = 0;
        end
      end
      if (in_valid && in_ready) begin
        advance_window(in_grad_x, in_grad_y, in_magnitude, in_drain);
      end
      thin_in_flight <= thin_pixels_q.size();
    end
  end

endmodule

// ===== tb/gradient_non_max_suppression_top_tb.sv =====
module gradient_non_max_suppression_top_tb;

  localparam int MAX_WIDTH = 2048;
  localparam int MAG_BITS = 16;
  localparam int GRAD_BITS = 16;
  localparam int SETTLE_CYCLES = 20;
  localparam int SMALL_WORDS = 1000;
  localparam int TRUNC_CAP = 200;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [gnms_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gnms_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic signed [GRAD_BITS-1:0]     in_grad_x;
  logic signed [GRAD_BITS-1:0]     in_grad_y;
  logic [MAG_BITS-1:0]             in_magnitude;
  logic                            in_drain;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [MAG_BITS-1:0]             out_thin_magnitude;
  logic                            out_end_of_row;
  logic                            out_end_of_frame;

  int mismatch_count;
  int thin_in_flight;
  int thin_checked;

  int burst_left;
  bit gaps_on;
  int mag_style;
  int cur_w;
  int cur_h;
  int eff_w;
  int eff_h;
  int words_sent;
  int drains_ignored;
  int frames_done;
  int reg_writes;

  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_stall_left = 0;

  gradient_non_max_suppression_top #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAG_BITS(MAG_BITS),
    .GRAD_BITS(GRAD_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_grad_x(in_grad_x),
    .in_grad_y(in_grad_y),
    .in_magnitude(in_magnitude),
    .in_drain(in_drain),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_thin_magnitude(out_thin_magnitude),
    .out_end_of_row(out_end_of_row),
    .out_end_of_frame(out_end_of_frame)
  );

  thin_edge_checker #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAG_BITS(MAG_BITS),
    .GRAD_BITS(GRAD_BITS)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_grad_x(in_grad_x),
    .in_grad_y(in_grad_y),
    .in_magnitude(in_magnitude),
    .in_drain(in_drain),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_thin_magnitude(out_thin_magnitude),
    .out_end_of_row(out_end_of_row),
    .out_end_of_frame(out_end_of_frame),
    .mismatch_count(mismatch_count),
    .thin_in_flight(thin_in_flight),
    .thin_checked(thin_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(32, 256);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) != 0);
      default: begin
        if (rx_stall_left != 0) begin
          out_ready <= 1'b0;
          rx_stall_left <= rx_stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          out_ready <= 1'b0;
          rx_stall_left <= $urandom_range(1, 16);
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  function automatic logic [15:0] rand16();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  task automatic send_word(input logic [15:0] gx, input logic [15:0] gy,
                           input logic [15:0] mag, input logic drain);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_grad_x <= gx;
    in_grad_y <= gy;
    in_magnitude <= mag;
    in_drain <= drain;
    do @(negedge clk); while (in_ready !== 1'b1);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (thin_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input bit do_w, input logic [12:0] wval,
                           input bit do_h, input logic [12:0] hval);
    if (do_w) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= gnms_pkg::REG_IMAGE_WIDTH;
      cfg_data <= wval;
      @(posedge clk);
      cur_w = wval[11:0];
      reg_writes++;
    end
    if (do_h) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= gnms_pkg::REG_IMAGE_HEIGHT;
      cfg_data <= hval;
      @(posedge clk);
      cur_h = hval;
      reg_writes++;
    end
    cfg_wr_en <= 1'b0;
    eff_w = (cur_w < 3) ? 3 : (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
    eff_h = (cur_h < 3) ? 3 : (cur_h > 4096) ? 4096 : cur_h;
  endtask

  task automatic make_pixel(output logic [15:0] gx, output logic [15:0] gy,
                            output logic [15:0] mag);
    int ax, ay, t;
    case ($urandom_range(0, 7))
      1: begin
        gx = '0;
        gy = '0;
      end
      2: begin
        gx = rand16();
        ay = $urandom_range(0, 511) - 256;
        gy = ay[15:0];
      end
      3: begin
        ax = $urandom_range(0, 511) - 256;
        gx = ax[15:0];
        gy = rand16();
      end
      4: begin
        ax = $urandom_range(1, 32767);
        ay = ax;
        if ($urandom_range(0, 1) == 1) ax = -ax;
        if ($urandom_range(0, 1) == 1) ay = -ay;
        gx = ax[15:0];
        gy = ay[15:0];
      end
      5: begin
        ax = $urandom_range(1, 32767);
        ay = ((27146 * ax) >>> 16) + $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 1) begin
          t = ax;
          ax = ay;
          ay = t;
        end
        if ($urandom_range(0, 1) == 1) ax = -ax;
        if ($urandom_range(0, 1) == 1) ay = -ay;
        gx = ax[15:0];
        gy = ay[15:0];
      end
      6: begin
        case ($urandom_range(0, 4))
          0: gx = 16'h8000;
          1: gx = 16'hffff;
          2: gx = 16'h0000;
          3: gx = 16'h0001;
          default: gx = 16'h7fff;
        endcase
        case ($urandom_range(0, 4))
          0: gy = 16'h8000;
          1: gy = 16'hffff;
          2: gy = 16'h0000;
          3: gy = 16'h0001;
          default: gy = 16'h7fff;
        endcase
      end
      default: begin
        gx = rand16();
        gy = rand16();
      end
    endcase
    case (mag_style)
      0: mag = rand16();
      1: begin
        t = $urandom_range(0, 3);
        mag = t[15:0];
      end
      2: begin
        case ($urandom_range(0, 3))
          0: mag = 16'h0000;
          1: mag = 16'h0001;
          2: mag = 16'hfffe;
          default: mag = 16'hffff;
        endcase
      end
      default: begin
        t = $urandom_range(0, 40);
        mag = t[15:0];
      end
    endcase
  endtask

  task automatic send_frame(input bit truncate);
    int positions, stop, p, pause_at, last;
    logic [15:0] gx, gy, mag;
    positions = eff_w * eff_h + eff_w + 1;
    last = (positions > TRUNC_CAP) ? TRUNC_CAP : positions - 1;
    stop = truncate ? $urandom_range(1, last) : positions;
    pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, stop - 1) : -1;
    mag_style = $urandom_range(0, 3);
    for (p = 0; p < stop; p++) begin
      if (p == pause_at) wait_idle();
      if (p < eff_w * eff_h) begin
        if ($urandom_range(0, 19) == 0) begin
          send_word(rand16(), rand16(), rand16(), 1'b1);
          drains_ignored++;
        end
        make_pixel(gx, gy, mag);
        send_word(gx, gy, mag, 1'b0);
      end else begin
        send_word(rand16(), rand16(), rand16(), ($urandom_range(0, 1) == 1));
      end
    end
    if (!truncate) frames_done++;
  endtask

  initial begin
    int phase, small_words, start_words, start_drains, pick, nframes, f, wv, hv;
    logic [15:0] gx, gy, mag;
    logic [12:0] wdata;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_grad_x = '0;
    in_grad_y = '0;
    in_magnitude = '0;
    in_drain = 1'b0;
    burst_left = 0;
    gaps_on = 1'b0;
    mag_style = 0;
    cur_w = 640;
    cur_h = 480;
    words_sent = 0;
    drains_ignored = 0;
    frames_done = 0;
    reg_writes = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame: each direction, field extremes, the tangent boundary, a drain word
    // inside the frame, and tail words that carry data with and without the drain flag.
    configure(1'b1, 13'd3, 1'b1, 13'd3);
    send_word(16'h7fff, 16'h0000, 16'hffff, 1'b0);
    send_word(16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_word(16'h0000, 16'h0000, 16'd100, 1'b0);
    send_word(16'd1234, 16'hfffb, 16'd777, 1'b1);
    drains_ignored++;
    send_word(16'h8000, 16'h8000, 16'd200, 1'b0);
    send_word(16'd100, 16'hff9c, 16'hffff, 1'b0);
    send_word(16'd1000, 16'd414, 16'd500, 1'b0);
    wait_idle();
    send_word(16'd1000, 16'd415, 16'd300, 1'b0);
    send_word(16'h7fff, 16'h7fff, 16'hffff, 1'b0);
    send_word(16'h0000, 16'h0001, 16'h0001, 1'b0);
    send_word(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_word(16'hffff, 16'hffff, 16'hffff, 1'b0);
    send_word(16'd5, 16'd5, 16'd5, 1'b1);
    send_word(16'h7fff, 16'h8000, 16'd40000, 1'b0);
    frames_done++;
    wait_idle();

    // A frame is left partway through, so the next register write restarts the raster position mid-frame.
    configure(1'b1, 13'd4, 1'b0, 13'd0);
    mag_style = 3;
    repeat (6) begin
      make_pixel(gx, gy, mag);
      send_word(gx, gy, mag, 1'b0);
    end
    wait_idle();

    phase = 0;
    small_words = 0;
    while (small_words < SMALL_WORDS) begin
      start_words = words_sent;
      start_drains = drains_ignored;
      if (phase == 1) begin
        gaps_on = 1'b1;
        configure(1'b1, 13'd4095, 1'b1, 13'd0);
        send_frame(1'b1);
      end else if (phase == 3) begin
        gaps_on = 1'b0;
        configure(1'b1, 13'd1, 1'b1, 13'd8191);
        send_frame(1'b1);
      end else begin
        pick = (phase == 0) ? 2 : $urandom_range(0, 2);
        wv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        wdata = wv[12:0];
        wdata[12] = ($urandom_range(0, 1) == 1);
        configure(pick != 1, wdata, pick != 0, hv[12:0]);
        gaps_on = ($urandom_range(0, 3) != 0);
        nframes = $urandom_range(1, 3);
        for (f = 0; f < nframes; f++) begin
          send_frame((f == nframes - 1) && ($urandom_range(0, 4) == 0));
        end
      end
      small_words += (words_sent - start_words) - (drains_ignored - start_drains);
      wait_idle();
      phase++;
    end

    $display("Sent %0d words (%0d drain words inside frames) over %0d whole frames",
             words_sent, drains_ignored, frames_done);
    $display("and %0d register writes; %0d thinned pixels were compared.",
             reg_writes, thin_checked);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches were found.", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run timed out with %0d thinned pixels still outstanding.", thin_in_flight);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
